// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID heater duty controller package
// Shared widths, register indexes and reset values of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  // stream and configuration widths
  localparam int DATA_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LIMIT_W     = 15;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KP             = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_DT          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KD_OVER_DT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MAX     = 3'd5;

  // register reset values
  localparam logic [DATA_W-1:0]  SETPOINT_RST       = 16'd3463;
  localparam logic [DATA_W-1:0]  KP_RST             = 16'd3072;
  localparam logic [DATA_W-1:0]  KI_DT_RST          = 16'd1966;
  localparam logic [DATA_W-1:0]  KD_OVER_DT_RST     = 16'd64000;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd100;
  localparam logic [DATA_W-1:0]  OUTPUT_MAX_RST     = 16'd1000;

endpackage

`default_nettype wire

// ===== rtl/pid_heater_duty_controller.sv =====
// ----------------------------------------------------------------------------
// PID heater duty controller
// Turns each temperature sample into a heater PWM duty value with a clamped
// integral term and saturated output.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata fields (low bit up)   notes
//  s_*       in         temperature[15:0] signed    one sample per beat
//  m_*       out        duty[15:0] unsigned         one duty per sample
//  cfg_*     in         cfg_data[15:0] by index     write only, no wait
//
//  Throughput is one beat per cycle while m_tready keeps the output moving;
//  a beat passes the input register (loaded on the accepting edge), then the
//  multiply stage and the output stage before m_tvalid rises. The integral
//  feedback closes inside the output stage.
//  rst is synchronous: it clears the pipeline, integral and last error and
//  loads the register defaults. With m_tready low the result holds and the
//  pipeline fills up to three beats, the held one included, before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_heater_duty_controller (
  input  logic                             clk,
  input  logic                             rst,
  // slave side: temperature[15:0]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pdc_pkg::DATA_W-1:0]       s_tdata,
  // master side: duty[15:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pdc_pkg::DATA_W-1:0]       m_tdata,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [pdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pdc_pkg::*;

  // configuration registers
  logic signed [15:0]        setpoint;
  logic [15:0]               kp;
  logic [15:0]               ki_dt;
  logic [15:0]               kd_over_dt;
  logic [LIMIT_W-1:0]        integral_limit;
  logic [15:0]               output_max;

  // controller state
  logic signed [15:0]        integral;
  logic signed [17:0]        last_error;

  // pipeline registers
  logic                      v0;
  logic signed [15:0]        temp0;
  logic                      v1;
  logic signed [33:0]        pterm1;
  logic signed [34:0]        dterm1;
  logic signed [33:0]        iprod1;
  logic                      o_valid;
  logic [15:0]               duty;

  // stage enables
  logic                      out_adv;
  logic                      en1;
  logic                      en0;

  // multiply stage logic
  logic signed [16:0]        err_c;
  logic signed [17:0]        derr_c;
  logic signed [16:0]        kp_s;
  logic signed [16:0]        ki_s;
  logic signed [16:0]        kd_s;
  logic signed [33:0]        pterm_c;
  logic signed [34:0]        dterm_c;
  logic signed [33:0]        iprod_c;

  // output stage logic
  logic signed [34:0]        acc_c;
  logic signed [34:0]        acc_t;
  logic signed [18:0]        acc_q;
  logic signed [18:0]        lim_c;
  logic signed [15:0]        integral_next;
  logic signed [35:0]        total_c;
  logic [27:0]               q_c;
  logic [15:0]               duty_next;

  // advance when the next stage is empty or moving
  assign out_adv  = !o_valid || m_tready;
  assign en1      = !v1 || out_adv;
  assign en0      = !v0 || en1;
  assign s_tready = en0;
  assign m_tvalid = o_valid;
  assign m_tdata  = duty;

  // error, derivative difference and the three gain products
  always_comb begin
    err_c   = 17'(setpoint) - 17'(temp0);
    derr_c  = 18'(err_c) - last_error;
    kp_s    = $signed({1'b0, kp});
    ki_s    = $signed({1'b0, ki_dt});
    kd_s    = $signed({1'b0, kd_over_dt});
    pterm_c = 34'(err_c) * 34'(kp_s);
    dterm_c = 35'(derr_c) * 35'(kd_s);
    iprod_c = 34'(err_c) * 34'(ki_s);
  end

  // integral update, clamp, sum and output saturation
  always_comb begin
    acc_c = $signed({{3{integral[15]}}, integral, 16'h0000}) + 35'(iprod1);
    // truncate toward zero: bias negative values before the shift
    if (acc_c[34]) begin
      acc_t = acc_c + 35'sd65535;
    end else begin
      acc_t = acc_c;
    end
    acc_q = acc_t[34:16];
    lim_c = $signed({4'b0000, integral_limit});
    if (acc_q > lim_c) begin
      integral_next = lim_c[15:0];
    end else if (acc_q < -lim_c) begin
      integral_next = 16'(-lim_c);
    end else begin
      integral_next = acc_q[15:0];
    end
    total_c = 36'(pterm1) + $signed({{12{integral_next[15]}}, integral_next, 8'h00})
              + 36'(dterm1);
    q_c = total_c[35:8];
    // a negative sum truncates to zero or below and saturates to zero
    if (total_c[35]) begin
      duty_next = 16'h0000;
    end else if (q_c > 28'(output_max)) begin
      duty_next = output_max;
    end else begin
      duty_next = q_c[15:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= SETPOINT_RST;
      kp             <= KP_RST;
      ki_dt          <= KI_DT_RST;
      kd_over_dt     <= KD_OVER_DT_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
      output_max     <= OUTPUT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:       setpoint       <= cfg_data;
        REG_KP:             kp             <= cfg_data;
        REG_KI_DT:          ki_dt          <= cfg_data;
        REG_KD_OVER_DT:     kd_over_dt     <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_MAX:     output_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valids and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      o_valid    <= 1'b0;
      integral   <= '0;
      last_error <= '0;
    end else begin
      if (en0) begin
        v0 <= s_tvalid;
      end
      if (en1) begin
        v1 <= v0;
        if (v0) begin
          last_error <= 18'(err_c);
        end
      end
      if (out_adv) begin
        o_valid <= v1;
        if (v1) begin
          integral <= integral_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en0 && s_tvalid) begin
      temp0 <= s_tdata;
    end
    if (en1 && v0) begin
      pterm1 <= pterm_c;
      dterm1 <= dterm_c;
      iprod1 <= iprod_c;
    end
    if (out_adv && v1) begin
      duty <= duty_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// PID heater duty controller port checker
// Watches the top-level ports for output holding, saturation, input readiness and draining.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [pdc_pkg::DATA_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [pdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pdc_pkg::*;

  logic [DATA_W-1:0] omax_shadow;
  logic              s_beat;

  assign s_beat = s_tvalid && s_tready;

  // track the output limit from the write port
  always_ff @(posedge clk) begin
    if (rst) begin
      omax_shadow <= OUTPUT_MAX_RST;
    end else if (cfg_we && (cfg_index == REG_OUTPUT_MAX)) begin
      omax_shadow <= cfg_data;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("duty beat changed while stalled");

  // duty never exceeds the output limit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= omax_shadow))
    else $error("duty above output limit");

  // a free output side never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with output ready");

  // with no new beats and a ready sink the pipeline drains
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!s_beat && m_tready) ##1 (!s_beat && m_tready) ##1 (!s_beat && m_tready)
      |=> !m_tvalid)
    else $error("result appeared without an input beat");

endmodule

bind pid_heater_duty_controller pdc_checker u_pdc_checker (.*);

`default_nettype wire
